// File: sv/conv3x3_pkg.sv
// Shared constants for the 3x3 padded image filter: field widths,
// configuration register indexes and reset values. No dependencies.
`default_nettype none

package conv3x3_pkg;

    localparam int MAX_SIZE_DEF   = 32;
    localparam int PIXEL_BITS_DEF = 16;

    localparam int SIZE_W     = 6;
    localparam int MASK_W     = 48;
    localparam int COEF_W     = 16;
    localparam int CONV_W     = 36;
    localparam int POS_W      = 5;
    localparam int OUT_DATA_W = 48;
    localparam int PAD_ONE    = 256;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = MASK_W;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_TOP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_MIDDLE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_BOTTOM = 2'd3;

    localparam logic [SIZE_W-1:0] IMAGE_SIZE_RST = 6'd30;

endpackage

`default_nettype wire

// File: sv/conv3x3_padded_image_filter.sv
// Top level of the 3x3 padded image filter: line stores, window, multiply and
// adder pipeline, output register. Depends on conv3x3_pkg.
// Pixels of an N x N image (N = image_size, 1..MAX_SIZE, 0 read as 1) enter in
// raster order, one beat per clock unless the result side stalls, as signed
// Q8.8; out-of-image neighbours count as 1.0. Each result is the exact Q20.16
// 3x3 weighted sum plus its row and column, in raster order. An input beat is
// taken every clock except that input is held after a pixel ending a row (row 1
// onward) while the right-edge result is issued, after the final pixel of a
// frame while the bottom row is flushed, and while the result side stalls; this
// is set by the single result port, one result per clock unless it stalls. A
// result passes the stage 1, window, product, row-sum and output registers.
// tlast marks the last result of a run, tuser the last result of the frame.
// Writing image_size restarts the frame; write configuration only when idle.
`default_nettype none

module conv3x3_padded_image_filter #(
    parameter int MAX_SIZE   = conv3x3_pkg::MAX_SIZE_DEF,
    parameter int PIXEL_BITS = conv3x3_pkg::PIXEL_BITS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_cfg_we,
    input  logic [conv3x3_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [conv3x3_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                     i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // [PIXEL_BITS-1:0] pixel, zero fill to whole bytes
    input  logic [((PIXEL_BITS + 7) / 8) * 8 - 1:0]  i_s_axis_tdata,
    output logic                                     o_m_axis_tvalid,
    input  logic                                     i_m_axis_tready,
    // [35:0] conv_value, [40:36] out_row, [45:41] out_col, [47:46] zero
    output logic [conv3x3_pkg::OUT_DATA_W-1:0]       o_m_axis_tdata,
    output logic                                     o_m_axis_tlast,  // run_last
    output logic                                     o_m_axis_tuser   // frame_last
);
    import conv3x3_pkg::*;

    localparam int CW = $clog2(MAX_SIZE);
    localparam int XW = (CW > POS_W) ? CW : POS_W;
    localparam int WB = (PIXEL_BITS > 10) ? PIXEL_BITS : 10;
    localparam int WP = WB + COEF_W;
    localparam int SW = (WP + 4 > CONV_W) ? WP + 4 : CONV_W;

    typedef enum logic [2:0] {
        ST_IN, ST_ROWEND, ST_FL_LOAD, ST_FL_PUSH, ST_FL_PAD
    } t_state;

    typedef enum logic [1:0] {OP_LOAD, OP_PUSH, OP_PAD} t_op;

    typedef enum logic [2:0] {SRC_B0, SRC_B1, SRC_B2, SRC_PIX, SRC_PAD} t_src;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             run_last;
        logic             frame_last;
    } t_meta;

    function automatic logic [POS_W-1:0] to_pos(input logic [CW-1:0] v);
        logic [XW-1:0] t;
        t = XW'(v);
        return t[POS_W-1:0];
    endfunction

    function automatic logic [1:0] mod_prev(input logic [1:0] m);
        return (m == 2'd0) ? 2'd2 : m - 2'd1;
    endfunction

    function automatic logic [1:0] mod_next(input logic [1:0] m);
        return (m == 2'd2) ? 2'd0 : m + 2'd1;
    endfunction

    function automatic t_src bank_src(input logic [1:0] m);
        case (m)
            2'd0:    return SRC_B0;
            2'd1:    return SRC_B1;
            default: return SRC_B2;
        endcase
    endfunction

    localparam logic signed [WB-1:0] PAD = WB'(PAD_ONE);

    // configuration
    logic [SIZE_W-1:0] r_image_size;
    logic [MASK_W-1:0] r_mask [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_size <= IMAGE_SIZE_RST;
            r_mask[0]    <= '0;
            r_mask[1]    <= '0;
            r_mask[2]    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IMAGE_SIZE:  r_image_size <= i_cfg_data[SIZE_W-1:0];
                CFG_MASK_TOP:    r_mask[0]    <= i_cfg_data[MASK_W-1:0];
                CFG_MASK_MIDDLE: r_mask[1]    <= i_cfg_data[MASK_W-1:0];
                CFG_MASK_BOTTOM: r_mask[2]    <= i_cfg_data[MASK_W-1:0];
            endcase
        end
    end

    logic [CW-1:0] last_idx;

    always_comb begin
        if (r_image_size == '0) begin
            last_idx = '0;
        end else if (r_image_size > SIZE_W'(MAX_SIZE)) begin
            last_idx = CW'(MAX_SIZE - 1);
        end else begin
            last_idx = CW'(r_image_size - 6'd1);
        end
    end

    // pipeline enables, from the output back
    logic r_s1_valid, r_win_valid, r_pr_valid, r_rs_valid, r_o_valid;
    logic en_out, en_rs, en_pr, en_win, en_s1;

    assign en_out = !r_o_valid || i_m_axis_tready;
    assign en_rs  = !r_rs_valid || en_out;
    assign en_pr  = !r_pr_valid || en_rs;
    assign en_win = !r_win_valid || en_pr;
    assign en_s1  = !r_s1_valid || en_win;

    // sequencer
    t_state        r_state;
    logic [CW-1:0] r_in_row, r_in_col, r_pend_row, r_fl_col;
    logic [1:0]    r_rmod, r_fl_mod;
    logic          r_pend_last;

    logic                  accept, in_last_col, pixel_last;
    logic [PIXEL_BITS-1:0] pixel;
    logic                  iss_valid;
    t_op                   iss_op;
    logic [CW-1:0]         iss_addr;
    t_src                  iss_src [3];
    t_meta                 iss_meta;
    t_src                  fl_top;

    assign o_s_axis_tready = (r_state == ST_IN) && en_s1;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign pixel           = i_s_axis_tdata[PIXEL_BITS-1:0];
    assign in_last_col     = (r_in_col == last_idx);
    assign pixel_last      = in_last_col && (r_in_row == last_idx);
    assign fl_top          = (last_idx != '0) ? bank_src(mod_prev(r_fl_mod)) : SRC_PAD;

    always_comb begin
        iss_valid  = 1'b0;
        iss_op     = OP_PUSH;
        iss_addr   = r_in_col;
        iss_src[0] = fl_top;
        iss_src[1] = bank_src(r_fl_mod);
        iss_src[2] = SRC_PAD;
        iss_meta   = '0;
        case (r_state)
            ST_IN: begin
                iss_valid           = accept && (r_in_row != '0);
                iss_op              = (r_in_col == '0) ? OP_LOAD : OP_PUSH;
                iss_src[0]          = (r_in_row > CW'(1)) ? bank_src(mod_next(r_rmod))
                                                         : SRC_PAD;
                iss_src[1]          = bank_src(mod_prev(r_rmod));
                iss_src[2]          = SRC_PIX;
                iss_meta.row        = to_pos(r_in_row - CW'(1));
                iss_meta.col        = to_pos(r_in_col - CW'(1));
                iss_meta.run_last   = !in_last_col;
            end
            ST_ROWEND: begin
                iss_valid           = en_s1;
                iss_op              = OP_PAD;
                iss_meta.row        = to_pos(r_pend_row);
                iss_meta.col        = to_pos(last_idx);
                iss_meta.run_last   = !r_pend_last;
            end
            ST_FL_LOAD: begin
                iss_valid           = en_s1;
                iss_op              = OP_LOAD;
                iss_addr            = '0;
            end
            ST_FL_PUSH: begin
                iss_valid           = en_s1;
                iss_addr            = r_fl_col;
                iss_meta.row        = to_pos(last_idx);
                iss_meta.col        = to_pos(r_fl_col - CW'(1));
            end
            ST_FL_PAD: begin
                iss_valid           = en_s1;
                iss_op              = OP_PAD;
                iss_meta.row        = to_pos(last_idx);
                iss_meta.col        = to_pos(last_idx);
                iss_meta.run_last   = 1'b1;
                iss_meta.frame_last = 1'b1;
            end
            default: iss_valid = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IN;
            r_in_row    <= '0;
            r_in_col    <= '0;
            r_rmod      <= '0;
            r_fl_mod    <= '0;
            r_fl_col    <= '0;
            r_pend_row  <= '0;
            r_pend_last <= 1'b0;
        end else if (i_cfg_we && i_cfg_index == CFG_IMAGE_SIZE) begin
            r_state  <= ST_IN;
            r_in_row <= '0;
            r_in_col <= '0;
            r_rmod   <= '0;
        end else begin
            case (r_state)
                ST_IN: begin
                    if (accept) begin
                        r_pend_row  <= r_in_row - CW'(1);
                        r_pend_last <= pixel_last;
                        if (pixel_last) begin
                            r_in_row <= '0;
                            r_in_col <= '0;
                            r_rmod   <= '0;
                            r_fl_mod <= r_rmod;
                        end else if (in_last_col) begin
                            r_in_col <= '0;
                            r_in_row <= r_in_row + CW'(1);
                            r_rmod   <= mod_next(r_rmod);
                        end else begin
                            r_in_col <= r_in_col + CW'(1);
                        end
                        if (r_in_row != '0 && in_last_col) begin
                            r_state <= ST_ROWEND;
                        end else if (pixel_last) begin
                            r_state <= ST_FL_LOAD;
                        end
                    end
                end
                ST_ROWEND: begin
                    if (en_s1) begin
                        r_state <= r_pend_last ? ST_FL_LOAD : ST_IN;
                    end
                end
                ST_FL_LOAD: begin
                    if (en_s1) begin
                        r_fl_col <= CW'(1);
                        r_state  <= (last_idx == '0) ? ST_FL_PAD : ST_FL_PUSH;
                    end
                end
                ST_FL_PUSH: begin
                    if (en_s1) begin
                        if (r_fl_col == last_idx) begin
                            r_state <= ST_FL_PAD;
                        end else begin
                            r_fl_col <= r_fl_col + CW'(1);
                        end
                    end
                end
                ST_FL_PAD: begin
                    if (en_s1) begin
                        r_state <= ST_IN;
                    end
                end
                default: r_state <= ST_IN;
            endcase
        end
    end

    // line stores: three rotating row banks
    logic [PIXEL_BITS-1:0] r_line [3][MAX_SIZE];
    logic [PIXEL_BITS-1:0] r_rd   [3];

    for (genvar g = 0; g < 3; g++) begin : g_bank
        always_ff @(posedge i_clk) begin
            if (accept && r_rmod == 2'(g)) begin
                r_line[g][r_in_col] <= pixel;
            end
            if (en_s1) begin
                r_rd[g] <= r_line[g][iss_addr];
            end
        end
    end

    // stage 1: read data and op
    t_op                   r_s1_op;
    t_src                  r_s1_src [3];
    t_meta                 r_s1_meta;
    logic [PIXEL_BITS-1:0] r_s1_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en_s1) begin
            r_s1_valid <= iss_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_s1 && iss_valid) begin
            r_s1_op     <= iss_op;
            r_s1_src[0] <= iss_src[0];
            r_s1_src[1] <= iss_src[1];
            r_s1_src[2] <= iss_src[2];
            r_s1_meta   <= iss_meta;
            r_s1_pix    <= pixel;
        end
    end

    logic signed [WB-1:0] col [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            case (r_s1_src[k])
                SRC_B0:  col[k] = WB'(signed'(r_rd[0]));
                SRC_B1:  col[k] = WB'(signed'(r_rd[1]));
                SRC_B2:  col[k] = WB'(signed'(r_rd[2]));
                SRC_PIX: col[k] = WB'(signed'(r_s1_pix));
                default: col[k] = PAD;
            endcase
        end
    end

    // stage 2: 3x3 window, [row][col], col 0 oldest
    logic signed [WB-1:0] r_win [3][3];
    t_meta                r_win_meta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_valid <= 1'b0;
        end else if (en_win) begin
            r_win_valid <= r_s1_valid && (r_s1_op != OP_LOAD);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && en_win) begin
            r_win_meta <= r_s1_meta;
            for (int k = 0; k < 3; k++) begin
                if (r_s1_op == OP_LOAD) begin
                    r_win[k][1] <= PAD;
                    r_win[k][2] <= col[k];
                end else begin
                    r_win[k][0] <= r_win[k][1];
                    r_win[k][1] <= r_win[k][2];
                    r_win[k][2] <= (r_s1_op == OP_PAD) ? PAD : col[k];
                end
            end
        end
    end

    // stage 3: products
    logic signed [COEF_W-1:0] coef   [3][3];
    logic signed [WP-1:0]     r_prod [3][3];
    t_meta                    r_pr_meta;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3; b++) begin
                coef[a][b] = signed'(r_mask[a][COEF_W * b +: COEF_W]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pr_valid <= 1'b0;
        end else if (en_pr) begin
            r_pr_valid <= r_win_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_pr && r_win_valid) begin
            r_pr_meta <= r_win_meta;
            for (int a = 0; a < 3; a++) begin
                for (int b = 0; b < 3; b++) begin
                    r_prod[a][b] <= r_win[a][b] * coef[a][b];
                end
            end
        end
    end

    // stage 4: row sums
    logic signed [SW-1:0] r_rs [3];
    t_meta                r_rs_meta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rs_valid <= 1'b0;
        end else if (en_rs) begin
            r_rs_valid <= r_pr_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_rs && r_pr_valid) begin
            r_rs_meta <= r_pr_meta;
            for (int a = 0; a < 3; a++) begin
                r_rs[a] <= SW'(r_prod[a][0]) + SW'(r_prod[a][1]) + SW'(r_prod[a][2]);
            end
        end
    end

    // output register
    logic signed [SW-1:0] total;
    logic [CONV_W-1:0]    r_o_conv;
    t_meta                r_o_meta;

    assign total = r_rs[0] + r_rs[1] + r_rs[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en_out) begin
            r_o_valid <= r_rs_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out && r_rs_valid) begin
            r_o_conv <= total[CONV_W-1:0];
            r_o_meta <= r_rs_meta;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {(OUT_DATA_W - CONV_W - 2 * POS_W)'(0),
                              r_o_meta.col, r_o_meta.row, r_o_conv};
    assign o_m_axis_tlast  = r_o_meta.run_last;
    assign o_m_axis_tuser  = r_o_meta.frame_last;

endmodule

`default_nettype wire

// File: dv/tb_conv3x3_padded_image_filter.sv
`timescale 1ns / 100ps
// Self-checking testbench for conv3x3_padded_image_filter: streams Q8.8 pixel
// frames over several image sizes and masks, predicts every Q20.16 result beat
// and checks them in order. Depends on conv3x3_pkg and the filter RTL.

module tb_conv3x3_padded_image_filter;
    import conv3x3_pkg::*;

    localparam int LINE_DEPTH    = MAX_SIZE_DEF;
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PIXELS = 150;

    typedef logic [PIXEL_BITS_DEF-1:0] t_pixel;

    typedef struct packed {
        logic [CONV_W-1:0] conv_value;
        logic [POS_W-1:0]  out_row;
        logic [POS_W-1:0]  out_col;
        logic              run_last;
        logic              frame_last;
    } t_conv_beat;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_reg_write;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_mode;

    class conv_scoreboard;
        logic [SIZE_W-1:0]  size_reg;
        logic [MASK_W-1:0]  mask_rows [3];
        logic signed [15:0] row_upper [LINE_DEPTH];
        logic signed [15:0] row_lower [LINE_DEPTH];
        logic signed [15:0] row_current [LINE_DEPTH];
        int                 in_row, in_col, emit_row, emit_col;
        t_conv_beat         conv_q[$];
        int                 errors;

        function new();
            size_reg = IMAGE_SIZE_RST;
            foreach (mask_rows[a]) mask_rows[a] = '0;
            foreach (row_upper[c]) begin
                row_upper[c]   = '0;
                row_lower[c]   = '0;
                row_current[c] = '0;
            end
            errors = 0;
            rewind();
        endfunction

        function void rewind();
            in_row   = 0;
            in_col   = 0;
            emit_row = 0;
            emit_col = 0;
        endfunction

        function int side();
            if (size_reg == 0) return 1;
            if (size_reg > LINE_DEPTH) return LINE_DEPTH;
            return int'(size_reg);
        endfunction

        function int pending();
            return conv_q.size();
        endfunction

        function longint coef(int a, int b);
            logic signed [COEF_W-1:0] c;
            c = mask_rows[a][COEF_W*b +: COEF_W];
            return longint'(c);
        endfunction

        // pixel (k,c) while input row r is being filled; outside reads as 1.0
        function longint neighbour(int k, int c, int r, int n);
            if (k < 0 || k >= n || c < 0 || c >= n) return PAD_ONE;
            if (k == r) return longint'(row_current[c]);
            if (k == r - 1) return longint'(row_lower[c]);
            if (k == r - 2) return longint'(row_upper[c]);
            return PAD_ONE;
        endfunction

        function void apply_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                CFG_IMAGE_SIZE: begin
                    size_reg = data[SIZE_W-1:0];
                    rewind();
                end
                CFG_MASK_TOP:    mask_rows[0] = data;
                CFG_MASK_MIDDLE: mask_rows[1] = data;
                CFG_MASK_BOTTOM: mask_rows[2] = data;
                default: ;
            endcase
        endfunction

        function void note_pixel(t_pixel px);
            int         n, p, total, tr, tc, a, b;
            longint     acc;
            t_conv_beat held;
            bit         have_held;
            n = side();
            have_held = 1'b0;
            held = '0;
            if (in_row >= n || in_col >= n || emit_row >= n || emit_col >= n) rewind();
            if (in_col == 0 && in_row > 0) begin
                row_upper = row_lower;
                row_lower = row_current;
            end
            row_current[in_col] = px;
            p = in_row * n + in_col;
            total = n * n;
            while (emit_row * n + emit_col < total) begin
                tr = (emit_row + 1 < n) ? emit_row + 1 : n - 1;
                tc = (emit_col + 1 < n) ? emit_col + 1 : n - 1;
                if (tr * n + tc > p) break;
                acc = 0;
                for (a = 0; a < 3; a++)
                    for (b = 0; b < 3; b++)
                        acc += coef(a, b) * neighbour(emit_row - 1 + a, emit_col - 1 + b,
                                                      in_row, n);
                if (have_held) conv_q.push_back(held);
                held.conv_value = acc[CONV_W-1:0];
                held.out_row    = emit_row[POS_W-1:0];
                held.out_col    = emit_col[POS_W-1:0];
                held.run_last   = 1'b0;
                held.frame_last = (emit_row == n - 1 && emit_col == n - 1);
                have_held = 1'b1;
                emit_col++;
                if (emit_col >= n) begin
                    emit_col = 0;
                    emit_row++;
                end
            end
            if (have_held) begin
                held.run_last = 1'b1;
                conv_q.push_back(held);
            end
            if (p + 1 >= total) begin
                rewind();
            end else begin
                in_col++;
                if (in_col >= n) begin
                    in_col = 0;
                    in_row++;
                end
            end
        endfunction

        function void check_beat(logic [OUT_DATA_W-1:0] data, logic last, logic user);
            t_conv_beat want;
            if (conv_q.size() == 0) begin
                $error("unexpected beat: row %0d col %0d", data[CONV_W +: POS_W],
                       data[CONV_W+POS_W +: POS_W]);
                errors++;
                return;
            end
            want = conv_q.pop_front();
            if (data[CONV_W-1:0] !== want.conv_value) begin
                $error("conv_value: expected %0d, got %0d", $signed(want.conv_value),
                       $signed(data[CONV_W-1:0]));
                errors++;
            end
            if (data[CONV_W +: POS_W] !== want.out_row) begin
                $error("out_row: expected %0d, got %0d", want.out_row, data[CONV_W +: POS_W]);
                errors++;
            end
            if (data[CONV_W+POS_W +: POS_W] !== want.out_col) begin
                $error("out_col: expected %0d, got %0d", want.out_col,
                       data[CONV_W+POS_W +: POS_W]);
                errors++;
            end
            if (last !== want.run_last) begin
                $error("run_last: expected %0d, got %0d", want.run_last, last);
                errors++;
            end
            if (user !== want.frame_last) begin
                $error("frame_last: expected %0d, got %0d", want.frame_last, user);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = CFG_IMAGE_SIZE;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [15:0]           i_s_axis_tdata  = '0;  // [15:0] pixel
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    // [35:0] conv_value, [40:36] out_row, [45:41] out_col, [47:46] zero
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  o_m_axis_tlast;
    logic                  o_m_axis_tuser;

    conv_scoreboard board = new();
    t_reg_write     pending_writes[$];
    int             burst_left  = 0;
    t_stall_mode    stall_mode  = STALL_NONE;
    int             stall_left  = 0;
    int unsigned    cycle_count = 0;

    conv3x3_padded_image_filter uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: check each beat, stall in changing modes
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            board.check_beat(o_m_axis_tdata, o_m_axis_tlast, o_m_axis_tuser);
        if (stall_left == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            stall_left <= $urandom_range(30, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            STALL_NONE:  i_m_axis_tready <= 1'b1;
            STALL_LIGHT: i_m_axis_tready <= ($urandom_range(0, 3) != 0);
            STALL_HEAVY: i_m_axis_tready <= ($urandom_range(0, 3) == 0);
            default:     i_m_axis_tready <= (cycle_count % 5 != 2);
        endcase
    end

    function automatic t_pixel random_pixel();
        case ($urandom_range(0, 11))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2:       return 16'hffff;
            3:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [MASK_W-1:0] random_mask();
        case ($urandom_range(0, 9))
            0:       return {3{16'h7fff}};
            1:       return {3{16'h8000}};
            2:       return '0;
            3:       return {16'h0000, 16'h0100, 16'h0000};
            default: return {16'($urandom), $urandom};
        endcase
    endfunction

    function automatic void stage_write(logic [CFG_IDX_W-1:0] index,
                                        logic [CFG_DATA_W-1:0] data);
        t_reg_write w;
        w.index = index;
        w.data  = data;
        pending_writes.push_back(w);
    endfunction

    // junk in the upper data bits must be ignored
    function automatic void stage_size(int n);
        stage_write(CFG_IMAGE_SIZE, {26'($urandom), 16'($urandom), 6'(n)});
    endfunction

    task automatic commit_writes();
        t_reg_write w;
        while (pending_writes.size() != 0) begin
            w = pending_writes.pop_front();
            i_cfg_we    <= 1'b1;
            i_cfg_index <= w.index;
            i_cfg_data  <= w.data;
            @(posedge i_clk);
            board.apply_reg(w.index, w.data);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic push_pixel(input t_pixel px);
        int gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= px;
        do @(posedge i_clk); while (!o_s_axis_tready);
        board.note_pixel(px);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // drain all expected beats, then let the pipeline go quiet
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int n, count, random_pixels;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single-pixel frames, extreme coefficients, back-to-back frames
        stage_size(1);
        stage_write(CFG_MASK_TOP, {3{16'h7fff}});
        stage_write(CFG_MASK_MIDDLE, {3{16'h8000}});
        stage_write(CFG_MASK_BOTTOM, {16'h8000, 16'h0100, 16'h7fff});
        commit_writes();
        push_pixel(16'h7fff);
        push_pixel(16'h8000);

        // size zero acts as one
        settle();
        stage_size(0);
        commit_writes();
        push_pixel(16'h0000);
        push_pixel(16'hffff);

        settle();
        stage_size(2);
        stage_write(CFG_MASK_TOP, {3{16'h8000}});
        commit_writes();
        push_pixel(16'h7fff);
        push_pixel(16'h8000);
        push_pixel(16'hffff);
        push_pixel(16'h5555);

        // mask change part way through a frame, no restart
        settle();
        stage_size(3);
        commit_writes();
        repeat (5) push_pixel(random_pixel());
        settle();
        stage_write(CFG_MASK_MIDDLE, {16'h0100, 16'hff00, 16'h0100});
        commit_writes();
        repeat (4) push_pixel(random_pixel());

        // size write abandons the frame in progress
        settle();
        stage_size(3);
        commit_writes();
        repeat (3) push_pixel(random_pixel());
        settle();
        stage_size(2);
        commit_writes();
        repeat (4) push_pixel(random_pixel());

        // oversize clamps to the line store depth
        settle();
        stage_size(40);
        commit_writes();
        repeat (2) push_pixel(random_pixel());

        // part of a full-width frame with random coefficients
        settle();
        stage_size(LINE_DEPTH);
        stage_write(CFG_MASK_TOP, random_mask());
        stage_write(CFG_MASK_MIDDLE, random_mask());
        stage_write(CFG_MASK_BOTTOM, random_mask());
        commit_writes();
        repeat (LINE_DEPTH * 3 + 5) push_pixel(random_pixel());

        random_pixels = 0;
        while (random_pixels < RANDOM_PIXELS) begin
            settle();
            if ($urandom_range(0, 4) != 0) begin
                case ($urandom_range(0, 9))
                    0:       stage_size(0);
                    1:       stage_size($urandom_range(33, 63));
                    2:       stage_size($urandom_range(7, 12));
                    default: stage_size($urandom_range(1, 6));
                endcase
            end
            if ($urandom_range(0, 1) != 0) stage_write(CFG_MASK_TOP, random_mask());
            if ($urandom_range(0, 1) != 0) stage_write(CFG_MASK_MIDDLE, random_mask());
            if ($urandom_range(0, 1) != 0) stage_write(CFG_MASK_BOTTOM, random_mask());
            commit_writes();
            n = board.side();
            if (n > 12)
                count = $urandom_range(1, 4 * n);
            else if ($urandom_range(0, 3) == 0)
                count = $urandom_range(1, n * n);
            else
                count = n * n * $urandom_range(1, 2);
            if (count > RANDOM_PIXELS - random_pixels)
                count = RANDOM_PIXELS - random_pixels;
            repeat (count) push_pixel(random_pixel());
            random_pixels += count;
        end

        settle();
        if (board.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
